@@ design/cclag_pkg.sv @@
// ----------------------------------------------------------------------------
// cclag_pkg
// Shared types and constants of the cross-correlation lag estimator.
// ----------------------------------------------------------------------------
package cclag_pkg;

	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FIELD_W         = 16;
	localparam int MAX_LAG_W       = 10;
	localparam int LAG_W           = 12;
	localparam int BEST_LAG_W      = 11;
	localparam int FRAC_W          = 16;
	localparam int PADDR_W         = 3;
	localparam int PDATA_W         = 32;

	typedef enum logic [1:0] {
		REG_MAX_LAG = 2'd0
	} reg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LAG_FIRST,
		OP_LAG_NEXT,
		OP_LAG_BM1,
		OP_LAG_BP1,
		OP_SCORE_SETUP,
		OP_MUL_CMP1,
		OP_MUL_CMP2,
		OP_TAKE,
		OP_SAVE_M,
		OP_SAVE_P,
		OP_MUL_A1,
		OP_MUL_A2,
		OP_MUL_C1,
		OP_MUL_C2,
		OP_MUL_B1,
		OP_MUL_B2,
		OP_SAVE_A,
		OP_SAVE_C,
		OP_SAVE_B,
		OP_NUM,
		OP_DEN,
		OP_DIV_START,
		OP_PUBLISH
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_LAG_FIRST,
		ST_SETUP,
		ST_SCORE,
		ST_CMP1,
		ST_CMP1_WAIT,
		ST_CMP2,
		ST_CMP2_WAIT,
		ST_DECIDE,
		ST_TAKE,
		ST_NEXT,
		ST_SAVE_M,
		ST_MUL_ISSUE,
		ST_MUL_WAIT,
		ST_NUM,
		ST_DEN
	} state_t;

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_MINUS,
		PH_PLUS
	} phase_t;

	typedef struct packed {
		dp_op_t op;
		logic   load;
	} dp_cmd_t;

	typedef struct packed {
		logic score_done;
		logic mul_done;
		logic div_done;
		logic diff_pos;
		logic lag_end;
		logic out_busy;
	} dp_stat_t;

endpackage

@@ design/cclag_mul.sv @@
// ----------------------------------------------------------------------------
// cclag_mul
// Shift-and-add multiply-accumulate: wide signed operand by an unsigned count.
// ----------------------------------------------------------------------------
module cclag_mul import cclag_pkg::*; #(
	parameter int PW = 84,
	parameter int CW = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 clr,
	input  logic signed [PW-1:0] a,
	input  logic        [CW-1:0] b,
	output logic signed [PW-1:0] acc,
	output logic                 busy
);

	logic signed [PW-1:0] a_q;
	logic        [CW-1:0] b_q;
	logic signed [PW-1:0] acc_q;
	logic                 busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && b_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			if (clr) begin
				acc_q <= '0;
			end
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign acc  = acc_q;
	assign busy = busy_q;

endmodule

@@ design/cclag_div.sv @@
// ----------------------------------------------------------------------------
// cclag_div
// Restoring divider for the parabolic fraction, one quotient bit a cycle,
// truncated toward zero and saturated to Q1.15.
// ----------------------------------------------------------------------------
module cclag_div import cclag_pkg::*; #(
	parameter int PW = 84
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [PW-1:0]     num,
	input  logic signed [PW-1:0]     den,
	output logic signed [FRAC_W-1:0] frac,
	output logic                     busy
);

	localparam int DW    = PW + FRAC_W;
	localparam int STEPS = FRAC_W;
	localparam int SC_W  = $clog2(STEPS + 1);

	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     dsh_q;
	logic [FRAC_W-1:0] q_q;
	logic              neg_q;
	logic              zero_q;
	logic [SC_W-1:0]   step_q;
	logic [PW-1:0]     num_abs;
	logic [PW-1:0]     den_abs;
	logic              ge;

	assign num_abs = num[PW-1] ? PW'(-num) : PW'(num);
	assign den_abs = den[PW-1] ? PW'(-den) : PW'(den);
	assign ge      = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= SC_W'(STEPS);
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= DW'(num_abs) << (FRAC_W - 2);
			dsh_q  <= DW'(den_abs) << (FRAC_W - 1);
			q_q    <= '0;
			neg_q  <= num[PW-1] ^ den[PW-1];
			zero_q <= den == '0;
		end else if (step_q != '0) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			q_q   <= {q_q[FRAC_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	always_comb begin
		if (zero_q) begin
			frac = '0;
		end else if (q_q[FRAC_W-1]) begin
			frac = neg_q ? {1'b1, {(FRAC_W-1){1'b0}}} : {1'b0, {(FRAC_W-1){1'b1}}};
		end else begin
			frac = neg_q ? -$signed({1'b0, q_q[FRAC_W-2:0]}) : $signed({1'b0, q_q[FRAC_W-2:0]});
		end
	end

	assign busy = step_q != '0;

endmodule

@@ design/cclag_dp.sv @@
// ----------------------------------------------------------------------------
// cclag_dp
// Datapath: sample stores, correlation pipeline, lag registers, products for
// the comparison and refinement, divider and result register.
// ----------------------------------------------------------------------------
module cclag_dp import cclag_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dp_cmd_t                      cmd,
	output dp_stat_t                     stat,
	input  logic        [MAX_LAG_W-1:0]  max_lag,
	input  logic signed [FIELD_W-1:0]    x_sample,
	input  logic signed [FIELD_W-1:0]    y_sample,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic signed [BEST_LAG_W-1:0] best_lag,
	output logic signed [FRAC_W-1:0]     lag_fraction
);

	localparam int SB    = SAMPLE_BITS;
	localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW    = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = 2 * SB + CW;
	localparam int PW    = 2 * SB + 3 * CW + 2;
	localparam int IW    = ((CW > LAG_W) ? CW : LAG_W) + 2;

	logic signed [SB-1:0] xmem [MAX_SAMPLES];
	logic signed [SB-1:0] ymem [MAX_SAMPLES];

	logic        [CW-1:0]     n_q;
	logic signed [LAG_W-1:0]  lag_q;
	logic signed [LAG_W-1:0]  best_lag_q;
	logic signed [IW-1:0]     idx_q;
	logic signed [IW-1:0]     end_q;
	logic                     iss_q;
	logic signed [SB-1:0]     rx_s1;
	logic signed [SB-1:0]     ry_s1;
	logic                     v_s1;
	logic signed [2*SB-1:0]   prod_s2;
	logic                     v_s2;
	logic signed [SUM_W-1:0]  sum_q;
	logic        [CW-1:0]     cnt_q;
	logic signed [SUM_W-1:0]  best_sum_q;
	logic        [CW-1:0]     best_cnt_q;
	logic signed [SUM_W-1:0]  sm_q;
	logic        [CW-1:0]     cm_q;
	logic signed [SUM_W-1:0]  sp_q;
	logic        [CW-1:0]     cp_q;
	logic signed [PW-1:0]     ra_q;
	logic signed [PW-1:0]     rb_q;
	logic signed [PW-1:0]     rc_q;
	logic signed [PW-1:0]     num_q;
	logic signed [PW-1:0]     tmp_q;
	logic signed [PW-1:0]     den_q;
	logic                     out_valid_q;
	logic signed [BEST_LAG_W-1:0] out_lag_q;
	logic signed [FRAC_W-1:0] out_frac_q;

	logic signed [31:0]       x_ext;
	logic signed [31:0]       y_ext;
	logic signed [IW-1:0]     lag_i;
	logic signed [IW-1:0]     n_i;
	logic signed [IW-1:0]     lo_i;
	logic signed [IW-1:0]     hi_i;
	logic signed [IW-1:0]     ovl_i;
	logic signed [IW-1:0]     yidx_i;
	logic                     store_wr;
	logic                     mul_start;
	logic                     mul_clr;
	logic signed [PW-1:0]     mul_a;
	logic        [CW-1:0]     mul_b;
	logic signed [PW-1:0]     mul_acc;
	logic                     mul_busy;
	logic signed [FRAC_W-1:0] div_frac;
	logic                     div_busy;

	assign x_ext    = 32'($unsigned(x_sample));
	assign y_ext    = 32'($unsigned(y_sample));
	assign store_wr = cmd.load && (n_q < CW'(MAX_SAMPLES));

	assign lag_i  = IW'(lag_q);
	assign n_i    = $signed(IW'(n_q));
	assign lo_i   = (lag_i > 0) ? lag_i : '0;
	assign hi_i   = n_i + ((lag_i < 0) ? lag_i : IW'(0));
	assign ovl_i  = hi_i - lo_i;
	assign yidx_i = idx_q - lag_i;

	// sample stores
	always_ff @(posedge clk) begin
		if (store_wr) begin
			xmem[n_q[AW-1:0]] <= x_ext[SB-1:0];
			ymem[n_q[AW-1:0]] <= y_ext[SB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		rx_s1   <= xmem[idx_q[AW-1:0]];
		ry_s1   <= ymem[yidx_i[AW-1:0]];
		prod_s2 <= rx_s1 * ry_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			iss_q       <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= iss_q;
			v_s2 <= v_s1;
			if (cmd.op == OP_PUBLISH) begin
				n_q <= '0;
			end else if (store_wr) begin
				n_q <= n_q + 1'b1;
			end
			if (cmd.op == OP_SCORE_SETUP) begin
				iss_q <= hi_i > lo_i;
			end else if (iss_q && (idx_q + IW'(1) == end_q)) begin
				iss_q <= 1'b0;
			end
			if (cmd.op == OP_PUBLISH) begin
				out_valid_q <= 1'b1;
			end else if (result_valid && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			sum_q <= sum_q + SUM_W'(prod_s2);
		end
		if (iss_q) begin
			idx_q <= idx_q + IW'(1);
		end
		unique case (cmd.op)
			OP_LAG_FIRST: lag_q <= -LAG_W'(max_lag);
			OP_LAG_NEXT:  lag_q <= lag_q + LAG_W'(1);
			OP_LAG_BM1:   lag_q <= best_lag_q - LAG_W'(1);
			OP_LAG_BP1:   lag_q <= best_lag_q + LAG_W'(1);
			OP_SCORE_SETUP: begin
				idx_q <= lo_i;
				end_q <= hi_i;
				sum_q <= '0;
				cnt_q <= (hi_i > lo_i) ? CW'(ovl_i) : CW'(1);
			end
			OP_TAKE: begin
				best_lag_q <= lag_q;
				best_sum_q <= sum_q;
				best_cnt_q <= cnt_q;
			end
			OP_SAVE_M: begin
				sm_q <= sum_q;
				cm_q <= cnt_q;
			end
			OP_SAVE_P: begin
				sp_q <= sum_q;
				cp_q <= cnt_q;
			end
			OP_SAVE_A: ra_q <= mul_acc;
			OP_SAVE_C: rc_q <= mul_acc;
			OP_SAVE_B: rb_q <= mul_acc;
			OP_NUM: begin
				num_q <= ra_q - rc_q;
				tmp_q <= ra_q + rc_q;
			end
			OP_DEN: den_q <= tmp_q - (rb_q <<< 1);
			OP_PUBLISH: begin
				out_lag_q  <= best_lag_q[BEST_LAG_W-1:0];
				out_frac_q <= div_frac;
			end
			default: begin
			end
		endcase
	end

	// operand selection for the shared multiplier
	always_comb begin
		mul_start = 1'b1;
		mul_clr   = 1'b1;
		mul_a     = PW'(sm_q);
		mul_b     = best_cnt_q;
		unique case (cmd.op)
			OP_MUL_CMP1: begin
				mul_a = PW'(sum_q);
				mul_b = best_cnt_q;
			end
			OP_MUL_CMP2: begin
				mul_clr = 1'b0;
				mul_a   = -PW'(best_sum_q);
				mul_b   = cnt_q;
			end
			OP_MUL_A1: begin
				mul_a = PW'(sm_q);
				mul_b = best_cnt_q;
			end
			OP_MUL_A2: begin
				mul_a = mul_acc;
				mul_b = cp_q;
			end
			OP_MUL_C1: begin
				mul_a = PW'(sp_q);
				mul_b = cm_q;
			end
			OP_MUL_C2: begin
				mul_a = mul_acc;
				mul_b = best_cnt_q;
			end
			OP_MUL_B1: begin
				mul_a = PW'(best_sum_q);
				mul_b = cm_q;
			end
			OP_MUL_B2: begin
				mul_a = mul_acc;
				mul_b = cp_q;
			end
			default: mul_start = 1'b0;
		endcase
	end

	cclag_mul #(
		.PW(PW),
		.CW(CW)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.clr   (mul_clr),
		.a     (mul_a),
		.b     (mul_b),
		.acc   (mul_acc),
		.busy  (mul_busy)
	);

	cclag_div #(
		.PW(PW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.op == OP_DIV_START),
		.num   (num_q),
		.den   (den_q),
		.frac  (div_frac),
		.busy  (div_busy)
	);

	assign stat.score_done = !iss_q && !v_s1 && !v_s2;
	assign stat.mul_done   = !mul_busy;
	assign stat.div_done   = !div_busy;
	assign stat.diff_pos   = !mul_acc[PW-1] && (mul_acc != '0);
	assign stat.lag_end    = lag_q == $signed(LAG_W'(max_lag));
	assign stat.out_busy   = out_valid_q && result_stall;

	assign result_valid = out_valid_q;
	assign best_lag     = out_lag_q;
	assign lag_fraction = out_frac_q;

endmodule

@@ design/cclag_ctrl.sv @@
// ----------------------------------------------------------------------------
// cclag_ctrl
// Controller: loading, lag search, neighbour scores, refinement sequence and
// hand-off of the result.
// ----------------------------------------------------------------------------
module cclag_ctrl import cclag_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  logic     last,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t     state_q, state_d;
	phase_t     phase_q, phase_d;
	logic       first_q, first_d;
	logic [2:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			phase_q <= PH_SEARCH;
			first_q <= 1'b0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			first_q <= first_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		first_d    = first_q;
		step_d     = step_q;
		cmd.op     = OP_NONE;
		cmd.load   = 1'b0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_LOAD: begin
				item_stall = 1'b0;
				cmd.load   = item_valid;
				if (item_valid && last) begin
					state_d = ST_LAG_FIRST;
				end
			end
			ST_LAG_FIRST: begin
				cmd.op  = OP_LAG_FIRST;
				phase_d = PH_SEARCH;
				first_d = 1'b1;
				state_d = ST_SETUP;
			end
			ST_SETUP: begin
				cmd.op  = OP_SCORE_SETUP;
				state_d = ST_SCORE;
			end
			ST_SCORE: begin
				if (stat.score_done) begin
					unique case (phase_q)
						PH_SEARCH: state_d = first_q ? ST_TAKE : ST_CMP1;
						PH_MINUS:  state_d = ST_SAVE_M;
						default: begin
							cmd.op  = OP_SAVE_P;
							step_d  = '0;
							state_d = ST_MUL_ISSUE;
						end
					endcase
				end
			end
			ST_CMP1: begin
				cmd.op  = OP_MUL_CMP1;
				state_d = ST_CMP1_WAIT;
			end
			ST_CMP1_WAIT: begin
				if (stat.mul_done) begin
					state_d = ST_CMP2;
				end
			end
			ST_CMP2: begin
				cmd.op  = OP_MUL_CMP2;
				state_d = ST_CMP2_WAIT;
			end
			ST_CMP2_WAIT: begin
				if (stat.mul_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = stat.diff_pos ? ST_TAKE : ST_NEXT;
			end
			ST_TAKE: begin
				cmd.op  = OP_TAKE;
				first_d = 1'b0;
				state_d = ST_NEXT;
			end
			ST_NEXT: begin
				if (stat.lag_end) begin
					cmd.op  = OP_LAG_BM1;
					phase_d = PH_MINUS;
				end else begin
					cmd.op = OP_LAG_NEXT;
				end
				state_d = ST_SETUP;
			end
			ST_SAVE_M: begin
				cmd.op  = OP_SAVE_M;
				phase_d = PH_PLUS;
				state_d = ST_NUM;
				// neighbour above is set up through the lag register next
				state_d = ST_MUL_WAIT;
				step_d  = 3'd7;
			end
			ST_MUL_ISSUE: begin
				unique case (step_q)
					3'd0:    cmd.op = OP_MUL_A1;
					3'd1:    cmd.op = OP_MUL_A2;
					3'd2:    cmd.op = OP_MUL_C1;
					3'd3:    cmd.op = OP_MUL_C2;
					3'd4:    cmd.op = OP_MUL_B1;
					default: cmd.op = OP_MUL_B2;
				endcase
				state_d = ST_MUL_WAIT;
			end
			ST_MUL_WAIT: begin
				if (step_q == 3'd7) begin
					cmd.op  = OP_LAG_BP1;
					state_d = ST_SETUP;
				end else if (stat.mul_done) begin
					if (step_q[0]) begin
						unique case (step_q)
							3'd1:    cmd.op = OP_SAVE_A;
							3'd3:    cmd.op = OP_SAVE_C;
							default: cmd.op = OP_SAVE_B;
						endcase
					end
					step_d  = step_q + 3'd1;
					state_d = (step_q == 3'd5) ? ST_NUM : ST_MUL_ISSUE;
				end
			end
			ST_NUM: begin
				if (step_q == 3'd6) begin
					cmd.op = OP_NUM;
					step_d = 3'd0;
					state_d = ST_DEN;
				end else if (step_q == 3'd0) begin
					if (stat.div_done) begin
						if (!stat.out_busy) begin
							cmd.op  = OP_PUBLISH;
							state_d = ST_LOAD;
						end
					end
				end
			end
			ST_DEN: begin
				if (step_q == 3'd0) begin
					cmd.op = OP_DEN;
					step_d = 3'd1;
				end else begin
					cmd.op  = OP_DIV_START;
					step_d  = 3'd0;
					state_d = ST_NUM;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

endmodule

@@ design/cross_correlation_lag_estimator.sv @@
// ----------------------------------------------------------------------------
// cross_correlation_lag_estimator
// Loads two signed sample sequences, searches the lag of greatest normalised
// cross-correlation and refines it by a parabola through its neighbours.
//
// Input channel (item_valid/item_stall): one beat carries one pair x_sample,
// y_sample; the beat with last set closes the sequence. Pairs beyond
// MAX_SAMPLES are dropped, their last flag still counts. Loading takes one
// pair a cycle; item_stall stays high from the last beat until the result
// has been placed in the output register.
// Output channel (result_valid/result_stall): one beat per sequence carrying
// best_lag and lag_fraction (Q1.15). The result waits in its register while
// the receiver stalls, and loading of the next sequence goes on meanwhile.
// Processing after the last beat: for each of the 2*max_lag+1 lags a score
// through the store read and multiply pipeline and, for every lag after the
// first, two products on the serial comparison multiplier; then two
// neighbour scores, six serial products and the division. The shared
// shift-add multiplier and the pipeline read port set the processing time.
// Reset empties the sample count and clears max_lag; stores hold no reset.
// max_lag sits at byte address 0 of the register port.
// ----------------------------------------------------------------------------
module cross_correlation_lag_estimator import cclag_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic        [PADDR_W-1:0]    paddr,
	input  logic        [PDATA_W-1:0]    pwdata,
	output logic        [PDATA_W-1:0]    prdata,
	output logic                         pready,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic signed [FIELD_W-1:0]    x_sample,
	input  logic signed [FIELD_W-1:0]    y_sample,
	input  logic                         last,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic signed [BEST_LAG_W-1:0] best_lag,
	output logic signed [FRAC_W-1:0]     lag_fraction
);

	logic [MAX_LAG_W-1:0] max_lag_q;
	logic                 reg_sel;
	dp_cmd_t              cmd;
	dp_stat_t             stat;

	assign reg_sel = {1'b0, paddr[PADDR_W-1:2]} == REG_MAX_LAG;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? PDATA_W'(max_lag_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lag_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			max_lag_q <= pwdata[MAX_LAG_W-1:0];
		end
	end

	cclag_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.last      (last),
		.stat      (stat),
		.cmd       (cmd)
	);

	cclag_dp #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.max_lag     (max_lag_q),
		.x_sample    (x_sample),
		.y_sample    (y_sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.best_lag    (best_lag),
		.lag_fraction(lag_fraction)
	);

endmodule
